FILE: rtl/core/double_array_trie_prefix_match_defines.svh
// Assertion macros used by the checker of the trie prefix matcher.
// Depends on nothing; included by the files that hold assertions.
`ifndef DOUBLE_ARRAY_TRIE_PREFIX_MATCH_DEFINES_SVH
`define DOUBLE_ARRAY_TRIE_PREFIX_MATCH_DEFINES_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define DATPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define DATPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/datpm_pkg.sv
// Shared types and constants of the trie prefix matcher.
// Depends on nothing; used by every module of the block except datpm_fifo.
package datpm_pkg;

    // Widths fixed by the request format.
    localparam int ID_W       = 12;
    localparam int TOKEN_ID_W = 10;
    localparam int BASE_W     = 13;

    // Reset values of the trie store.
    localparam logic [BASE_W-1:0] ROOT_BASE  = 13'h0001;
    localparam logic [BASE_W-1:0] NO_BASE    = 13'h1FFF;
    localparam logic [BASE_W-1:0] FREE_CHECK = 13'h1FFF;

    // Operation codes of a request.
    typedef enum logic [1:0] {
        OP_LOOKUP   = 2'd0,
        OP_REGISTER = 2'd1,
        OP_WRITE    = 2'd2
    } t_op;

    // One incoming request as taken from the ports.
    typedef struct packed {
        logic [1:0]        op;
        logic              first;
        logic [31:0]       token;
        logic [11:0]       entry_index;
        logic [BASE_W-1:0] entry_base;
        logic [BASE_W-1:0] entry_check;
        logic [15:0]       entry_block;
        logic              entry_block_valid;
    } t_item;

    // A classified request handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]            op;
        logic                  first;
        logic                  found;
        logic [ID_W-1:0]       tid;
        logic [TOKEN_ID_W-1:0] token_id;
        logic                  map_full;
        logic [11:0]           entry_index;
        logic [BASE_W-1:0]     entry_base;
        logic [BASE_W-1:0]     entry_check;
        logic [15:0]           entry_block;
        logic                  entry_block_valid;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic                  hit;
        logic [15:0]           block;
        logic [15:0]           prefix_len;
        logic                  walk_alive;
        logic [TOKEN_ID_W-1:0] token_id;
        logic                  map_full;
    } t_result;

    // One entry of the trie store.
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [BASE_W-1:0] check;
        logic [15:0]       block;
        logic              bvalid;
    } t_entry;

    // Front part states.
    typedef enum logic [1:0] {
        FS_IDLE,
        FS_SEARCH,
        FS_SEND
    } t_fstate;

    // Back part states.
    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_READ,
        BS_SEND
    } t_bstate;

endpackage

FILE: rtl/core/double_array_trie_prefix_match.sv
// Longest-prefix matcher over a double-array trie, with a hot-token id map.
// After reset the block holds full high while it sweeps the trie store to its initial
// contents. Requests are taken one at a time. A trie write or an unused code goes
// straight to the send state. A lookup or a hot-token registration first searches the
// hot-token memory, one entry per cycle through its single read port, until the token
// is found or all registered tokens are compared. The trie step of a lookup then passes
// through the back part's read and send states, the read being the registered read of
// the child entry, and overlaps the next search.
// A full result queue holds both parts until a result is popped.
// Depends on datpm_pkg, datpm_fifo, datpm_front and datpm_back.
module double_array_trie_prefix_match
    import datpm_pkg::*;
#(
    parameter int TRIE_DEPTH = 4096,
    parameter int MAP_DEPTH  = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_op,
    input  logic                  i_first,
    input  logic signed [31:0]    i_token,
    input  logic [11:0]           i_entry_index,
    input  logic signed [12:0]    i_entry_base,
    input  logic signed [12:0]    i_entry_check,
    input  logic [15:0]           i_entry_block,
    input  logic                  i_entry_block_valid,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_hit,
    output logic [15:0]           o_block,
    output logic [15:0]           o_prefix_len,
    output logic                  o_walk_alive,
    output logic [TOKEN_ID_W-1:0] o_token_id,
    output logic                  o_map_full
);

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_result);

    t_item      item;
    t_cmd       cmd_in;
    t_cmd       cmd_out;
    logic       cmd_push;
    logic       cmd_full;
    logic       cmd_pop;
    logic       cmd_empty;
    logic       clearing;
    t_result    res_in;
    t_result    res_out;
    logic       res_push;
    logic       res_full;

    // Gather the request fields.
    always_comb begin
        item.op                = i_op;
        item.first             = i_first;
        item.token             = i_token;
        item.entry_index       = i_entry_index;
        item.entry_base        = i_entry_base;
        item.entry_check       = i_entry_check;
        item.entry_block       = i_entry_block;
        item.entry_block_valid = i_entry_block_valid;
    end

    // Front part: hot-token map and classification.
    datpm_front #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (item),
        .i_hold     (clearing),
        .o_full     (full),
        .o_cmd      (cmd_in),
        .o_cmd_push (cmd_push),
        .i_cmd_full (cmd_full)
    );

    // Queue of classified requests between the two parts.
    datpm_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    // Back part: trie store and walk.
    datpm_back #(
        .TRIE_DEPTH (TRIE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res_in),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .o_clearing  (clearing)
    );

    // Result queue toward the consumer.
    datpm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_hit         = res_out.hit;
    assign o_block       = res_out.block;
    assign o_prefix_len  = res_out.prefix_len;
    assign o_walk_alive  = res_out.walk_alive;
    assign o_token_id    = res_out.token_id;
    assign o_map_full    = res_out.map_full;

endmodule

FILE: rtl/core/datpm_fifo.sv
// Small register queue used between the front and back parts and at the output.
// Depends on nothing.
module datpm_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Pointer and fill count updates, wrapping at the depth.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push_ok) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop_ok) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Payload slots need no reset.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/datpm_front.sv
// Front part: accepts requests, owns the hot-token map and classifies each request.
// Depends on datpm_pkg.
module datpm_front
    import datpm_pkg::*;
#(
    parameter int MAP_DEPTH = 1024
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_hold,
    output logic  o_full,
    output t_cmd  o_cmd,
    output logic  o_cmd_push,
    input  logic  i_cmd_full
);

    localparam int MW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int CW = $clog2(MAP_DEPTH + 1);

    logic [31:0]   r_map [MAP_DEPTH];

    t_fstate       r_state, n_state;
    t_item         r_item, n_item;
    t_cmd          r_cmd, n_cmd;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_cmp_vld;
    logic [MW-1:0] r_cmp_idx;
    logic [31:0]   r_rdata;

    logic          accept;
    logic          hit_now;
    logic          rd_en;
    logic          wr_en;
    logic          search_miss;
    logic          map_is_full;
    logic [ID_W-1:0] found_id;
    logic [ID_W-1:0] new_id;

    assign o_full      = (r_state != FS_IDLE) || i_hold;
    assign accept      = i_push && !o_full;
    assign o_cmd       = r_cmd;

    // The search compares one stored token per cycle against the request.
    assign hit_now     = r_cmp_vld && (r_rdata == r_item.token);
    assign rd_en       = (r_state == FS_SEARCH) && !hit_now && (r_idx < r_count);
    assign search_miss = (r_state == FS_SEARCH) && !r_cmp_vld && !(r_idx < r_count);
    assign map_is_full = (32'(r_count) >= 32'(MAP_DEPTH));
    assign found_id    = ID_W'(r_cmp_idx);
    assign new_id      = ID_W'(r_count[MW-1:0]);

    // Next state and classification.
    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_cmd      = r_cmd;
        n_count    = r_count;
        n_idx      = r_idx;
        wr_en      = 1'b0;
        o_cmd_push = 1'b0;
        if (rd_en) begin
            n_idx = r_idx + 1'b1;
        end
        case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    n_item                  = i_item;
                    n_idx                   = '0;
                    n_cmd.op                = i_item.op;
                    n_cmd.first             = i_item.first;
                    n_cmd.found             = 1'b0;
                    n_cmd.tid               = '0;
                    n_cmd.token_id          = '0;
                    n_cmd.map_full          = 1'b0;
                    n_cmd.entry_index       = i_item.entry_index;
                    n_cmd.entry_base        = i_item.entry_base;
                    n_cmd.entry_check       = i_item.entry_check;
                    n_cmd.entry_block       = i_item.entry_block;
                    n_cmd.entry_block_valid = i_item.entry_block_valid;
                    if ((i_item.op == OP_LOOKUP) || (i_item.op == OP_REGISTER)) begin
                        n_state = FS_SEARCH;
                    end else begin
                        n_state = FS_SEND;
                    end
                end
            end
            FS_SEARCH: begin
                if (hit_now) begin
                    n_cmd.found = 1'b1;
                    n_cmd.tid   = found_id;
                    if (r_item.op == OP_REGISTER) begin
                        n_cmd.token_id = found_id[TOKEN_ID_W-1:0];
                    end
                    n_state = FS_SEND;
                end else if (search_miss) begin
                    // A new token in a registration takes the next free id unless the map is full.
                    if (r_item.op == OP_REGISTER) begin
                        if (map_is_full) begin
                            n_cmd.map_full = 1'b1;
                        end else begin
                            wr_en          = 1'b1;
                            n_cmd.token_id = new_id[TOKEN_ID_W-1:0];
                            n_count        = r_count + 1'b1;
                        end
                    end
                    n_state = FS_SEND;
                end
            end
            FS_SEND: begin
                if (!i_cmd_full) begin
                    o_cmd_push = 1'b1;
                    n_state    = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FS_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_cmp_vld <= rd_en;
        end
    end

    // Request payload and classification result.
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_cmd     <= n_cmd;
        r_cmp_idx <= r_idx[MW-1:0];
    end

    // Hot-token memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[r_count[MW-1:0]] <= r_item.token;
        end
        if (rd_en) begin
            r_rdata <= r_map[r_idx[MW-1:0]];
        end
    end

endmodule

FILE: rtl/core/datpm_back.sv
// Back part: owns the trie store and the walk state, and produces one result per request.
// Depends on datpm_pkg.
module datpm_back
    import datpm_pkg::*;
#(
    parameter int TRIE_DEPTH = 4096
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_empty,
    output logic    o_cmd_pop,
    output t_result o_res,
    output logic    o_res_push,
    input  logic    i_res_full,
    output logic    o_clearing
);

    localparam int AW = $clog2(TRIE_DEPTH);

    t_entry            r_mem [TRIE_DEPTH];

    t_bstate           r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [AW-1:0]     r_node, n_node;
    logic [AW-1:0]     r_next, n_next;
    logic [BASE_W-1:0] r_node_base, n_node_base;
    logic [BASE_W-1:0] r_root_base, n_root_base;
    logic              r_running, n_running;
    logic [15:0]       r_tokens, n_tokens;
    logic [15:0]       r_best_len, n_best_len;
    logic [15:0]       r_best_block, n_best_block;
    logic              r_best_valid, n_best_valid;
    logic [TOKEN_ID_W-1:0] r_tid_out, n_tid_out;
    logic              r_full_out, n_full_out;
    t_entry            r_rdata;

    logic              we;
    logic [AW-1:0]     waddr;
    t_entry            wdata;
    logic              re;
    logic [AW-1:0]     raddr;

    logic              first_now;
    logic              running_eff;
    logic [BASE_W-1:0] base_eff;
    logic [BASE_W:0]   child;
    logic [31:0]       child_wide;
    logic              child_ok;
    logic              check_ok;
    logic [31:0]       idx_wide;
    logic [15:0]       tokens_inc;

    assign o_clearing = (r_state == BS_CLEAR);

    // Child index is the signed base of the current node plus the dense token id.
    assign first_now   = (i_cmd.op == OP_LOOKUP) && i_cmd.first;
    assign running_eff = first_now || r_running;
    assign base_eff    = first_now ? r_root_base : r_node_base;
    assign child       = {base_eff[BASE_W-1], base_eff} + {2'b00, i_cmd.tid};
    assign child_wide  = {19'b0, child[BASE_W-1:0]};
    assign child_ok    = !child[BASE_W] && (child_wide < 32'(TRIE_DEPTH));
    assign check_ok    = !r_rdata.check[BASE_W-1] &&
                         ({20'b0, r_rdata.check[11:0]} == 32'(r_node));
    assign idx_wide    = {20'b0, i_cmd.entry_index};
    assign tokens_inc  = (r_tokens == 16'hFFFF) ? r_tokens : r_tokens + 1'b1;

    // Result fields come straight from the walk registers.
    always_comb begin
        o_res.hit         = r_best_valid;
        o_res.block       = r_best_block;
        o_res.prefix_len  = r_best_len;
        o_res.walk_alive  = r_running;
        o_res.token_id    = r_tid_out;
        o_res.map_full    = r_full_out;
    end

    // Next state, trie access and walk update.
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_node       = r_node;
        n_next       = r_next;
        n_node_base  = r_node_base;
        n_root_base  = r_root_base;
        n_running    = r_running;
        n_tokens     = r_tokens;
        n_best_len   = r_best_len;
        n_best_block = r_best_block;
        n_best_valid = r_best_valid;
        n_tid_out    = r_tid_out;
        n_full_out   = r_full_out;
        we           = 1'b0;
        waddr        = '0;
        wdata        = '0;
        re           = 1'b0;
        raddr        = child_wide[AW-1:0];
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        case (r_state)
            BS_CLEAR: begin
                // Sweep the store once after reset; the root gets base one.
                we           = 1'b1;
                waddr        = r_clr_addr;
                wdata.base   = (r_clr_addr == '0) ? ROOT_BASE : NO_BASE;
                wdata.check  = FREE_CHECK;
                wdata.block  = '0;
                wdata.bvalid = 1'b0;
                n_clr_addr   = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(TRIE_DEPTH - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop  = 1'b1;
                    n_tid_out  = '0;
                    n_full_out = 1'b0;
                    n_state    = BS_SEND;
                    case (i_cmd.op)
                        OP_LOOKUP: begin
                            if (first_now) begin
                                n_node       = '0;
                                n_node_base  = r_root_base;
                                n_running    = 1'b1;
                                n_tokens     = '0;
                                n_best_len   = '0;
                                n_best_block = '0;
                                n_best_valid = 1'b0;
                            end
                            if (running_eff) begin
                                if (!i_cmd.found || !child_ok) begin
                                    n_running = 1'b0;
                                end else begin
                                    re      = 1'b1;
                                    n_next  = child_wide[AW-1:0];
                                    n_state = BS_READ;
                                end
                            end
                        end
                        OP_REGISTER: begin
                            n_tid_out  = i_cmd.token_id;
                            n_full_out = i_cmd.map_full;
                        end
                        OP_WRITE: begin
                            if (idx_wide < 32'(TRIE_DEPTH)) begin
                                we           = 1'b1;
                                waddr        = idx_wide[AW-1:0];
                                wdata.base   = i_cmd.entry_base;
                                wdata.check  = i_cmd.entry_check;
                                wdata.block  = i_cmd.entry_block;
                                wdata.bvalid = i_cmd.entry_block_valid;
                                // Keep the cached bases in step with the store.
                                if (i_cmd.entry_index == '0) begin
                                    n_root_base = i_cmd.entry_base;
                                end
                                if (idx_wide == 32'(r_node)) begin
                                    n_node_base = i_cmd.entry_base;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BS_READ: begin
                // The child entry must name the current node as its parent.
                if (check_ok) begin
                    n_node      = r_next;
                    n_node_base = r_rdata.base;
                    n_tokens    = tokens_inc;
                    if (r_rdata.bvalid) begin
                        n_best_block = r_rdata.block;
                        n_best_valid = 1'b1;
                        n_best_len   = tokens_inc;
                    end
                end else begin
                    n_running = 1'b0;
                end
                n_state = BS_SEND;
            end
            BS_SEND: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_CLEAR;
            r_clr_addr   <= '0;
            r_node       <= '0;
            r_node_base  <= ROOT_BASE;
            r_root_base  <= ROOT_BASE;
            r_running    <= 1'b1;
            r_tokens     <= '0;
            r_best_len   <= '0;
            r_best_block <= '0;
            r_best_valid <= 1'b0;
            r_tid_out    <= '0;
            r_full_out   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_node       <= n_node;
            r_node_base  <= n_node_base;
            r_root_base  <= n_root_base;
            r_running    <= n_running;
            r_tokens     <= n_tokens;
            r_best_len   <= n_best_len;
            r_best_block <= n_best_block;
            r_best_valid <= n_best_valid;
            r_tid_out    <= n_tid_out;
            r_full_out   <= n_full_out;
        end
    end

    // Child address held for the cycle the store answers.
    always_ff @(posedge i_clk) begin
        r_next <= n_next;
    end

    // Trie store: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

endmodule

FILE: rtl/core/datpm_checker.sv
// Port-level checks of the trie prefix matcher, bound to the top level.
// Depends on datpm_pkg and the assertion macro header.
`include "double_array_trie_prefix_match_defines.svh"

module datpm_checker
    import datpm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  empty,
    input logic                  pop,
    input logic                  o_hit,
    input logic [15:0]           o_block,
    input logic [15:0]           o_prefix_len,
    input logic [TOKEN_ID_W-1:0] o_token_id,
    input logic                  o_map_full
);

    // A refused registration never carries an id.
    `DATPM_ASSERT_IMPLY(a_full_no_id, i_clk, i_rst_n, !empty && o_map_full,
        o_token_id == '0, "map full with nonzero id")

    // Without a matched prefix the block handle reads as zero.
    `DATPM_ASSERT_IMPLY(a_miss_no_block, i_clk, i_rst_n, !empty && !o_hit,
        o_block == '0, "block without hit")

    // A matched prefix is at least one token long.
    `DATPM_ASSERT_IMPLY(a_hit_has_len, i_clk, i_rst_n, !empty && o_hit,
        o_prefix_len != '0, "hit with zero length")

    // A waiting result stays put until it is taken.
    `DATPM_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_prefix_len) && $stable(o_block) && $stable(o_token_id),
        "waiting result changed")

endmodule

bind double_array_trie_prefix_match datpm_checker u_checker (.*);
